// File: rtl/bpbb_pkg.sv
// Shared constants, types and helpers of the 0-1 branch-and-bound solver.
package bpbb_pkg;

  localparam int MAX_VARS   = 64;
  localparam int MAX_ROWS   = 1024;
  localparam int VAR_W      = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int VCNT_W     = $clog2(MAX_VARS + 1);
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RCNT_W     = $clog2(MAX_ROWS + 1);
  localparam int COEF_DEPTH = MAX_ROWS * MAX_VARS;
  localparam int CADDR_W    = $clog2(COEF_DEPTH);

  localparam int COEF_W  = 16;
  localparam int RHS_W   = 24;
  localparam int REL_W   = 2;
  localparam int PS_W    = 24;
  localparam int RB_W    = REL_W + RHS_W;
  localparam int SUM_W   = 32;
  localparam int ALU_W   = 34;

  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

  localparam logic [1:0] CFG_SENSE = 2'd0;
  localparam logic [1:0] CFG_NVARS = 2'd1;
  localparam logic [1:0] CFG_NROWS = 2'd2;

  localparam logic [REL_W-1:0] REL_LE = 2'd0;
  localparam logic [REL_W-1:0] REL_EQ = 2'd1;
  localparam logic [REL_W-1:0] REL_GE = 2'd2;

  typedef enum logic [1:0] {
    FN_OBJ   = 2'd0,
    FN_COEF  = 2'd1,
    FN_ROW   = 2'd2,
    FN_SOLVE = 2'd3
  } func_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    func_t              func;
    logic [9:0]         row;
    logic [5:0]         var_req;
    logic [COEF_W-1:0]  coeff;
    logic [REL_W-1:0]   relation;
    logic [RHS_W-1:0]   rhs;
  } in_item_t;

  typedef struct packed {
    logic               coef_we;
    logic [CADDR_W-1:0] coef_waddr;
    logic [COEF_W-1:0]  coef_wdata;
    logic [CADDR_W-1:0] coef_raddr;
    logic               obj_we;
    logic [VAR_W-1:0]   obj_waddr;
    logic [COEF_W-1:0]  obj_wdata;
    logic [VAR_W-1:0]   obj_raddr;
    logic               rb_we;
    logic [ROW_W-1:0]   rb_waddr;
    logic [RB_W-1:0]    rb_wdata;
    logic               ps_we;
    logic [ROW_W-1:0]   ps_waddr;
    logic [PS_W-1:0]    ps_wdata;
    logic [ROW_W-1:0]   row_raddr;
  } mem_req_t;

  typedef struct packed {
    logic [COEF_W-1:0]  coef;
    logic [COEF_W-1:0]  obj;
    logic [RB_W-1:0]    rb;
    logic [PS_W-1:0]    ps;
  } mem_rsp_t;

  function automatic logic [CADDR_W-1:0] coef_addr(input logic [ROW_W-1:0] r,
                                                   input logic [VAR_W-1:0] v);
    return CADDR_W'(r) * CADDR_W'(MAX_VARS) + CADDR_W'(v);
  endfunction

  function automatic logic signed [ALU_W-1:0] sx16(input logic [15:0] v);
    return ALU_W'($signed(v));
  endfunction

  function automatic logic signed [ALU_W-1:0] sx24(input logic [23:0] v);
    return ALU_W'($signed(v));
  endfunction

  function automatic logic signed [ALU_W-1:0] sx32(input logic [31:0] v);
    return ALU_W'($signed(v));
  endfunction

endpackage

// File: rtl/bpbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpbb_ram #(
  parameter int W = 16,
  parameter int D = 64
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                        wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                        rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bpbb_alu.sv
// Shared add/subtract unit with less-than and greater-than flags for compares.
module bpbb_alu
  import bpbb_pkg::*;
(
  input  alu_op_t                 op,
  input  logic signed [ALU_W-1:0] a,
  input  logic signed [ALU_W-1:0] b,
  output logic signed [ALU_W-1:0] res,
  output logic                    lt,
  output logic                    gt
);

  assign res = (op == ALU_SUB) ? (a - b) : (a + b);
  assign lt  = res[ALU_W-1];
  assign gt  = !res[ALU_W-1] && (res != '0);

endmodule

// File: rtl/bpbb_seq.sv
// Search sequencer: loads, depth-first branch and bound, clearing pass.
module bpbb_seq
  import bpbb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  in_item_t                 in_item,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic                     out_feasible,
  output logic [SUM_W-1:0]         out_best,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_addr,
  input  logic [10:0]              cfg_wdata,
  output mem_req_t                 mreq,
  input  mem_rsp_t                 mrsp
);

  typedef enum logic [24:0] {
    S_CLR    = 25'd1 << 0,
    S_IDLE   = 25'd1 << 1,
    S_ENTER  = 25'd1 << 2,
    S_ROW_RD = 25'd1 << 3,
    S_ROW_EV = 25'd1 << 4,
    S_SUM_RD = 25'd1 << 5,
    S_SUM_AC = 25'd1 << 6,
    S_CMP    = 25'd1 << 7,
    S_POST   = 25'd1 << 8,
    S_NU_ORD = 25'd1 << 9,
    S_NU_OCK = 25'd1 << 10,
    S_NU_CRD = 25'd1 << 11,
    S_NU_CCK = 25'd1 << 12,
    S_OPT_RD = 25'd1 << 13,
    S_OPT_AC = 25'd1 << 14,
    S_PR_ADD = 25'd1 << 15,
    S_PR_CMP = 25'd1 << 16,
    S_CONT   = 25'd1 << 17,
    S_COL_RD = 25'd1 << 18,
    S_COL_WR = 25'd1 << 19,
    S_OBJ_RD = 25'd1 << 20,
    S_OBJ_AC = 25'd1 << 21,
    S_PAR    = 25'd1 << 22,
    S_PAR_CK = 25'd1 << 23,
    S_DONE   = 25'd1 << 24
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    sense_r, sense_nxt;
  logic [6:0]              nvc_r, nvc_nxt;
  logic [10:0]             nrc_r, nrc_nxt;
  logic [VCNT_W-1:0]       nv_r, nv_nxt;
  logic [RCNT_W-1:0]       nr_r, nr_nxt;
  logic [RCNT_W-1:0]       i_r, i_nxt;
  logic [VCNT_W-1:0]       j_r, j_nxt;
  logic [VAR_W-1:0]        x_r, x_nxt;
  logic [VAR_W-1:0]        v_r, v_nxt;
  logic [VAR_W-1:0]        nx_r, nx_nxt;
  logic                    open_r, open_nxt;
  logic                    wp_r, wp_nxt;
  logic                    dir_r, dir_nxt;
  logic                    found_r, found_nxt;
  logic signed [ALU_W-1:0] aux_r, aux_nxt;
  logic signed [ALU_W-1:0] bnd_r, bnd_nxt;
  logic signed [ALU_W-1:0] opt_r, opt_nxt;
  logic signed [ALU_W-1:0] tmp_r, tmp_nxt;
  logic [SUM_W-1:0]        rs_r, rs_nxt;
  logic [SUM_W-1:0]        best_r, best_nxt;
  logic [MAX_VARS-1:0]     path_r, path_nxt;
  logic [MAX_VARS-1:0]     val_r, val_nxt;
  logic [CADDR_W-1:0]      clr_r, clr_nxt;
  logic                    ovld_r, ovld_nxt;
  logic                    ofeas_r, ofeas_nxt;
  logic [SUM_W-1:0]        obest_r, obest_nxt;

  alu_op_t                 alu_op;
  logic signed [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic                    alu_lt, alu_gt;

  logic [VCNT_W-1:0]       x_inc;
  logic                    c_pos, c_neg, o_pos, o_neg;
  logic [REL_W-1:0]        rel;

  bpbb_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .lt  (alu_lt),
    .gt  (alu_gt)
  );

  assign x_inc = VCNT_W'(x_r) + VCNT_W'(1);
  assign c_pos = !mrsp.coef[COEF_W-1] && (mrsp.coef != '0);
  assign c_neg = mrsp.coef[COEF_W-1];
  assign o_pos = !mrsp.obj[COEF_W-1] && (mrsp.obj != '0);
  assign o_neg = mrsp.obj[COEF_W-1];
  assign rel   = mrsp.rb[RB_W-1 -: REL_W];

  assign in_tready    = (state_r == S_IDLE);
  assign out_tvalid   = ovld_r;
  assign out_feasible = ofeas_r;
  assign out_best     = obest_r;

  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_r)
      S_ROW_EV: begin
        alu_op = ALU_SUB;
        alu_a  = sx24(mrsp.ps);
        alu_b  = sx24(mrsp.rb[RHS_W-1:0]);
      end
      S_SUM_AC: begin
        alu_a = aux_r;
        alu_b = sx16(mrsp.coef);
      end
      S_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = aux_r;
        alu_b  = bnd_r;
      end
      S_POST: begin
        alu_op = ALU_SUB;
        alu_a  = sx32(rs_r);
        alu_b  = sx32(best_r);
      end
      S_OPT_AC: begin
        alu_a = opt_r;
        alu_b = sx16(mrsp.obj);
      end
      S_PR_ADD: begin
        alu_a = sx32(rs_r);
        alu_b = opt_r;
      end
      S_PR_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = tmp_r;
        alu_b  = sx32(best_r);
      end
      S_COL_WR: begin
        alu_op = dir_r ? ALU_ADD : ALU_SUB;
        alu_a  = sx24(mrsp.ps);
        alu_b  = sx16(mrsp.coef);
      end
      S_OBJ_AC: begin
        alu_op = dir_r ? ALU_ADD : ALU_SUB;
        alu_a  = sx32(rs_r);
        alu_b  = sx16(mrsp.obj);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sense_nxt = sense_r;
    nvc_nxt   = nvc_r;
    nrc_nxt   = nrc_r;
    nv_nxt    = nv_r;
    nr_nxt    = nr_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    x_nxt     = x_r;
    v_nxt     = v_r;
    nx_nxt    = nx_r;
    open_nxt  = open_r;
    wp_nxt    = wp_r;
    dir_nxt   = dir_r;
    found_nxt = found_r;
    aux_nxt   = aux_r;
    bnd_nxt   = bnd_r;
    opt_nxt   = opt_r;
    tmp_nxt   = tmp_r;
    rs_nxt    = rs_r;
    best_nxt  = best_r;
    path_nxt  = path_r;
    val_nxt   = val_r;
    clr_nxt   = clr_r;
    ovld_nxt  = ovld_r && !out_tready;
    ofeas_nxt = ofeas_r;
    obest_nxt = obest_r;

    mreq            = '0;
    mreq.row_raddr  = i_r[ROW_W-1:0];
    mreq.coef_raddr = coef_addr(i_r[ROW_W-1:0],
                                (state_r == S_COL_RD) ? v_r : j_r[VAR_W-1:0]);
    mreq.obj_raddr  = (state_r == S_OBJ_RD) ? v_r : j_r[VAR_W-1:0];

    if (cfg_we) begin
      case (cfg_addr)
        CFG_SENSE: sense_nxt = cfg_wdata[0];
        CFG_NVARS: nvc_nxt   = cfg_wdata[6:0];
        CFG_NROWS: nrc_nxt   = cfg_wdata;
        default:   sense_nxt = sense_r;
      endcase
    end

    unique case (state_r)
      S_CLR: begin
        mreq.coef_we    = 1'b1;
        mreq.coef_waddr = clr_r;
        if (clr_r < CADDR_W'(MAX_VARS)) begin
          mreq.obj_we    = 1'b1;
          mreq.obj_waddr = clr_r[VAR_W-1:0];
        end
        if (int'(clr_r) < MAX_ROWS) begin
          mreq.rb_we    = 1'b1;
          mreq.rb_waddr = ROW_W'(clr_r);
          mreq.ps_we    = 1'b1;
          mreq.ps_waddr = ROW_W'(clr_r);
        end
        if (clr_r == CADDR_W'(COEF_DEPTH - 1)) begin
          clr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + CADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_item.func)
            FN_OBJ: begin
              mreq.obj_we    = (int'(in_item.var_req) < MAX_VARS);
              mreq.obj_waddr = VAR_W'(in_item.var_req);
              mreq.obj_wdata = in_item.coeff;
            end
            FN_COEF: begin
              mreq.coef_we    = (int'(in_item.var_req) < MAX_VARS) &&
                                (int'(in_item.row) < MAX_ROWS);
              mreq.coef_waddr = coef_addr(ROW_W'(in_item.row), VAR_W'(in_item.var_req));
              mreq.coef_wdata = in_item.coeff;
            end
            FN_ROW: begin
              mreq.rb_we    = (int'(in_item.row) < MAX_ROWS);
              mreq.rb_waddr = ROW_W'(in_item.row);
              mreq.rb_wdata = {in_item.relation, in_item.rhs};
            end
            FN_SOLVE: begin
              nv_nxt    = (int'(nvc_r) > MAX_VARS) ? VCNT_W'(MAX_VARS) : VCNT_W'(nvc_r);
              nr_nxt    = (int'(nrc_r) > MAX_ROWS) ? RCNT_W'(MAX_ROWS) : RCNT_W'(nrc_r);
              best_nxt  = sense_r ? SUM_MIN : SUM_MAX;
              found_nxt = 1'b0;
              rs_nxt    = '0;
              path_nxt  = '0;
              val_nxt   = '0;
              v_nxt     = '0;
              state_nxt = S_ENTER;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ENTER: begin
        path_nxt[v_r] = 1'b1;
        val_nxt[v_r]  = 1'b0;
        x_nxt         = v_r;
        i_nxt         = '0;
        open_nxt      = 1'b0;
        state_nxt     = S_ROW_RD;
      end
      S_ROW_RD: begin
        state_nxt = (i_r == nr_r) ? S_POST : S_ROW_EV;
      end
      S_ROW_EV: begin
        i_nxt     = i_r + RCNT_W'(1);
        state_nxt = S_ROW_RD;
        case (rel)
          REL_GE: begin
            if (alu_lt) begin
              wp_nxt    = 1'b1;
              state_nxt = S_SUM_RD;
            end
          end
          REL_EQ: begin
            if (alu_lt || alu_gt) begin
              wp_nxt    = alu_lt;
              state_nxt = S_SUM_RD;
            end
          end
          REL_LE: begin
            if (alu_gt) begin
              wp_nxt    = 1'b0;
              state_nxt = S_SUM_RD;
            end
          end
          default: state_nxt = S_ROW_RD;
        endcase
        if (state_nxt == S_SUM_RD) begin
          i_nxt    = i_r;
          open_nxt = 1'b1;
          aux_nxt  = sx24(mrsp.ps);
          bnd_nxt  = sx24(mrsp.rb[RHS_W-1:0]);
          j_nxt    = x_inc;
        end
      end
      S_SUM_RD: begin
        state_nxt = (j_r >= nv_r) ? S_CMP : S_SUM_AC;
      end
      S_SUM_AC: begin
        if (wp_r ? c_pos : c_neg) begin
          aux_nxt = alu_res;
        end
        j_nxt     = j_r + VCNT_W'(1);
        state_nxt = S_SUM_RD;
      end
      S_CMP: begin
        if (wp_r ? alu_lt : alu_gt) begin
          v_nxt     = x_r;
          state_nxt = S_CONT;
        end else begin
          i_nxt     = i_r + RCNT_W'(1);
          state_nxt = S_ROW_RD;
        end
      end
      S_POST: begin
        if (!open_r) begin
          found_nxt = 1'b1;
          if (sense_r ? alu_gt : alu_lt) begin
            best_nxt = rs_r;
          end
        end
        if (open_r && (x_inc == nv_r)) begin
          v_nxt     = x_r;
          state_nxt = S_CONT;
        end else begin
          j_nxt     = x_inc;
          state_nxt = S_NU_ORD;
        end
      end
      S_NU_ORD: begin
        if (j_r >= nv_r) begin
          v_nxt     = x_r;
          state_nxt = S_CONT;
        end else begin
          state_nxt = S_NU_OCK;
        end
      end
      S_NU_OCK, S_NU_CCK: begin
        if ((state_r == S_NU_OCK) ? (mrsp.obj != '0) : (mrsp.coef != '0)) begin
          nx_nxt = j_r[VAR_W-1:0];
          if (open_r) begin
            v_nxt     = j_r[VAR_W-1:0];
            state_nxt = S_ENTER;
          end else begin
            opt_nxt   = '0;
            state_nxt = S_OPT_RD;
          end
        end else begin
          i_nxt     = (state_r == S_NU_OCK) ? '0 : i_r + RCNT_W'(1);
          state_nxt = S_NU_CRD;
        end
      end
      S_NU_CRD: begin
        if (i_r == nr_r) begin
          j_nxt     = j_r + VCNT_W'(1);
          state_nxt = S_NU_ORD;
        end else begin
          state_nxt = S_NU_CCK;
        end
      end
      S_OPT_RD: begin
        state_nxt = (j_r >= nv_r) ? S_PR_ADD : S_OPT_AC;
      end
      S_OPT_AC: begin
        if (sense_r ? o_pos : o_neg) begin
          opt_nxt = alu_res;
        end
        j_nxt     = j_r + VCNT_W'(1);
        state_nxt = S_OPT_RD;
      end
      S_PR_ADD: begin
        tmp_nxt   = alu_res;
        state_nxt = S_PR_CMP;
      end
      S_PR_CMP: begin
        if (sense_r ? alu_gt : alu_lt) begin
          v_nxt     = nx_r;
          state_nxt = S_ENTER;
        end else begin
          v_nxt     = x_r;
          state_nxt = S_CONT;
        end
      end
      S_CONT: begin
        dir_nxt   = !val_r[v_r];
        i_nxt     = '0;
        state_nxt = S_COL_RD;
      end
      S_COL_RD: begin
        state_nxt = (i_r == nr_r) ? S_OBJ_RD : S_COL_WR;
      end
      S_COL_WR: begin
        mreq.ps_we    = 1'b1;
        mreq.ps_waddr = i_r[ROW_W-1:0];
        mreq.ps_wdata = alu_res[PS_W-1:0];
        i_nxt         = i_r + RCNT_W'(1);
        state_nxt     = S_COL_RD;
      end
      S_OBJ_RD: begin
        state_nxt = S_OBJ_AC;
      end
      S_OBJ_AC: begin
        rs_nxt = alu_res[SUM_W-1:0];
        if (dir_r) begin
          val_nxt[v_r] = 1'b1;
          x_nxt        = v_r;
          i_nxt        = '0;
          open_nxt     = 1'b0;
          state_nxt    = S_ROW_RD;
        end else begin
          val_nxt[v_r]  = 1'b0;
          path_nxt[v_r] = 1'b0;
          state_nxt     = S_PAR;
        end
      end
      S_PAR: begin
        if (v_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          v_nxt     = v_r - VAR_W'(1);
          state_nxt = S_PAR_CK;
        end
      end
      S_PAR_CK: begin
        if (path_r[v_r]) begin
          state_nxt = S_CONT;
        end else begin
          v_nxt = v_r - VAR_W'(1);
        end
      end
      S_DONE: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt  = 1'b1;
          ofeas_nxt = found_r;
          obest_nxt = best_r;
          clr_nxt   = '0;
          state_nxt = S_CLR;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      sense_r <= 1'b1;
      nvc_r   <= 7'd1;
      nrc_r   <= '0;
      clr_r   <= '0;
      ovld_r  <= 1'b0;
      found_r <= 1'b0;
      path_r  <= '0;
      val_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sense_r <= sense_nxt;
      nvc_r   <= nvc_nxt;
      nrc_r   <= nrc_nxt;
      clr_r   <= clr_nxt;
      ovld_r  <= ovld_nxt;
      found_r <= found_nxt;
      path_r  <= path_nxt;
      val_r   <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nv_r    <= nv_nxt;
    nr_r    <= nr_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    x_r     <= x_nxt;
    v_r     <= v_nxt;
    nx_r    <= nx_nxt;
    open_r  <= open_nxt;
    wp_r    <= wp_nxt;
    dir_r   <= dir_nxt;
    aux_r   <= aux_nxt;
    bnd_r   <= bnd_nxt;
    opt_r   <= opt_nxt;
    tmp_r   <= tmp_nxt;
    rs_r    <= rs_nxt;
    best_r  <= best_nxt;
    ofeas_r <= ofeas_nxt;
    obest_r <= obest_nxt;
  end

  a_node_on_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW_RD) |-> path_r[x_r])
    else $error("node variable is not on the branch path");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW_RD) |-> (i_r <= nr_r))
    else $error("row counter ran past the row count");

  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !ovld_r) |=> (ovld_r && state_r == S_CLR))
    else $error("finished solve did not post a result and start clearing");

endmodule

// File: rtl/binary_program_branch_and_bound.sv
// 0-1 integer program solver (depth-first branch and bound). After reset and after
// every solve the block runs a clearing pass over all MAX_ROWS*MAX_VARS coefficient
// entries (65536) with in_tready low; configuration writes are still taken. Load words
// (func 0..2) are written straight into the memories while the block is idle. A solve
// word holds the block busy for a data-dependent time set by the shared add/compare
// unit and the registered coefficient memory: every node scans the active rows one by
// one and sums the coefficients of each open row, the next-variable search reads
// objective and column entries one at a time, and every branch step updates the row
// sums one row at a time. The result word waits in an output register until taken.
module binary_program_branch_and_bound
  import bpbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // row, var_req, coeff, relation, rhs, zero pad
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // feasible, best_value, zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [10:0] cfg_wdata
);

  in_item_t         item;
  mem_req_t         mreq;
  mem_rsp_t         mrsp;
  logic             feas;
  logic [SUM_W-1:0] best;

  assign item.func     = func_t'(in_tuser);
  assign item.row      = in_tdata[9:0];
  assign item.var_req  = in_tdata[15:10];
  assign item.coeff    = in_tdata[31:16];
  assign item.relation = in_tdata[33:32];
  assign item.rhs      = in_tdata[57:34];

  assign out_tdata = {7'd0, best, feas};

  bpbb_ram #(.W(COEF_W), .D(COEF_DEPTH)) u_coef (
    .clk   (clk),
    .we    (mreq.coef_we),
    .waddr (mreq.coef_waddr),
    .wdata (mreq.coef_wdata),
    .raddr (mreq.coef_raddr),
    .rdata (mrsp.coef)
  );

  bpbb_ram #(.W(COEF_W), .D(MAX_VARS)) u_obj (
    .clk   (clk),
    .we    (mreq.obj_we),
    .waddr (mreq.obj_waddr),
    .wdata (mreq.obj_wdata),
    .raddr (mreq.obj_raddr),
    .rdata (mrsp.obj)
  );

  bpbb_ram #(.W(RB_W), .D(MAX_ROWS)) u_rb (
    .clk   (clk),
    .we    (mreq.rb_we),
    .waddr (mreq.rb_waddr),
    .wdata (mreq.rb_wdata),
    .raddr (mreq.row_raddr),
    .rdata (mrsp.rb)
  );

  bpbb_ram #(.W(PS_W), .D(MAX_ROWS)) u_ps (
    .clk   (clk),
    .we    (mreq.ps_we),
    .waddr (mreq.ps_waddr),
    .wdata (mreq.ps_wdata),
    .raddr (mreq.row_raddr),
    .rdata (mrsp.ps)
  );

  bpbb_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_item      (item),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_feasible (feas),
    .out_best     (best),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .mreq         (mreq),
    .mrsp         (mrsp)
  );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the 0-1 branch-and-bound solver: directed table plus random problems.
`timescale 1ns / 1ps

module tb_top;
  import bpbb_pkg::*;

  localparam int CYCLE_LIMIT = 40_000_000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic { ROW_WORD = 1'b0, ROW_CFG = 1'b1 } step_kind_t;

  typedef struct {
    step_kind_t        kind;
    func_t             func;
    logic [9:0]        row;
    logic [5:0]        var_req;
    logic signed [15:0] coeff;
    logic [1:0]        relation;
    logic signed [23:0] rhs;
    logic [1:0]        cfg_idx;
    logic [10:0]       cfg_val;
    bit                typed;
    bit                t_feas;
    logic signed [31:0] t_best;
  } step_t;

  typedef struct {
    bit                feas;
    logic signed [31:0] best;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [10:0] cfg_wdata;

  binary_program_branch_and_bound dut (.*);

  // solver state mirror
  bit          sense_r;
  logic [6:0]  nvars_r;
  logic [10:0] nrows_r;
  int          coef_mem [COEF_DEPTH];
  logic [1:0]  row_rel [MAX_ROWS];
  int          row_rhs [MAX_ROWS];
  longint      row_acc [MAX_ROWS];
  int          obj_coef [MAX_VARS];
  longint      best_obj;
  bit          any_feasible;
  int          nv;
  int          nr;

  verdict_t    pending_q[$];
  int          mismatches;
  int          solves_seen;
  bit          hold_long;
  longint      cycles;
  step_t       directed[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("binary_program_branch_and_bound verification failed");
      $finish;
    end
  end

  function automatic int rows_status(int x);
    int open;
    longint aux;
    longint b;
    bit want_pos;
    int c;
    open = 0;
    for (int i = 0; i < nr; i++) begin
      aux = row_acc[i];
      b = row_rhs[i];
      if (row_rel[i] == REL_GE && aux < b) want_pos = 1;
      else if (row_rel[i] == REL_EQ && aux > b) want_pos = 0;
      else if (row_rel[i] == REL_EQ && aux < b) want_pos = 1;
      else if (row_rel[i] == REL_LE && aux > b) want_pos = 0;
      else continue;
      open = 1;
      for (int j = x + 1; j < nv; j++) begin
        c = coef_mem[i * MAX_VARS + j];
        if (want_pos ? (c > 0) : (c < 0)) aux += c;
      end
      if (want_pos ? (aux < b) : (aux > b)) return -1;
    end
    return open;
  endfunction

  function automatic int next_var(int from);
    for (int j = from; j < nv; j++) begin
      if (j < 0) continue;
      if (obj_coef[j] != 0) return j;
      for (int i = 0; i < nr; i++)
        if (coef_mem[i * MAX_VARS + j] != 0) return j;
    end
    return -1;
  endfunction

  function automatic void shift_column(int v, int dir);
    for (int i = 0; i < nr; i++) row_acc[i] += dir * coef_mem[i * MAX_VARS + v];
  endfunction

  function automatic void explore(int x, longint sum);
    int t;
    int nx;
    longint opt;
    t = rows_status(x);
    if (t < 0) return;
    if (t == 0) begin
      any_feasible = 1;
      if (sense_r ? (sum > best_obj) : (sum < best_obj)) best_obj = sum;
    end else if (x == nv - 1) begin
      return;
    end
    nx = next_var(x + 1);
    if (nx < 0) return;
    if (t == 0) begin
      opt = 0;
      for (int k = nx; k < nv; k++)
        if (sense_r ? (obj_coef[k] > 0) : (obj_coef[k] < 0)) opt += obj_coef[k];
      if (sense_r ? !(sum + opt > best_obj) : !(sum + opt < best_obj)) return;
    end
    explore(nx, sum);
    shift_column(nx, 1);
    explore(nx, sum + obj_coef[nx]);
    shift_column(nx, -1);
  endfunction

  function automatic void clear_problem();
    foreach (coef_mem[i]) coef_mem[i] = 0;
    foreach (row_rel[i]) begin
      row_rel[i] = REL_LE;
      row_rhs[i] = 0;
      row_acc[i] = 0;
    end
    foreach (obj_coef[i]) obj_coef[i] = 0;
  endfunction

  function automatic verdict_t solve_problem();
    verdict_t r;
    nv = (nvars_r > MAX_VARS) ? MAX_VARS : int'(nvars_r);
    nr = (nrows_r > MAX_ROWS) ? MAX_ROWS : int'(nrows_r);
    best_obj = sense_r ? longint'(SUM_MIN) : longint'(SUM_MAX);
    any_feasible = 0;
    foreach (row_acc[i]) row_acc[i] = 0;
    explore(0, 0);
    shift_column(0, 1);
    explore(0, obj_coef[0]);
    r.feas = any_feasible;
    r.best = best_obj[31:0];
    clear_problem();
    return r;
  endfunction

  function automatic void apply_word(step_t s);
    case (s.func)
      FN_OBJ:  obj_coef[s.var_req] = s.coeff;
      FN_COEF: coef_mem[int'(s.row) * MAX_VARS + s.var_req] = s.coeff;
      FN_ROW: begin
        row_rel[s.row] = s.relation;
        row_rhs[s.row] = s.rhs;
      end
      default: ;
    endcase
  endfunction

  task automatic drain_and_settle();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SENSE: sense_r = val[0];
      CFG_NVARS: nvars_r = val[6:0];
      default:   nrows_r = val;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(step_t s);
    int gap;
    verdict_t v;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= s.func;
    in_tdata <= {6'b0, s.rhs, s.relation, s.coeff, s.var_req, s.row};
    do @(posedge clk); while (!in_tready);
    if (s.func == FN_SOLVE) begin
      v = solve_problem();
      if (s.typed && (v.feas != s.t_feas || v.best != s.t_best))
        $display("table row disagrees with predictor: %0d/%0d vs %0d/%0d",
                 s.t_feas, s.t_best, v.feas, v.best);
      if (s.typed) begin
        v.feas = s.t_feas;
        v.best = s.t_best;
      end
      pending_q.push_back(v);
    end else begin
      apply_word(s);
    end
  endtask

  task automatic run_step(step_t s);
    if (s.kind == ROW_CFG) begin
      in_tvalid <= 1'b0;
      drain_and_settle();
      write_reg(s.cfg_idx, s.cfg_val);
    end else begin
      send_word(s);
    end
  endtask

  function automatic step_t mk_word(func_t f, int r, int v, int c, int rel, int b);
    step_t s;
    s.kind = ROW_WORD;
    s.func = f;
    s.row = 10'(r);
    s.var_req = 6'(v);
    s.coeff = 16'(c);
    s.relation = 2'(rel);
    s.rhs = 24'(b);
    s.cfg_idx = CFG_SENSE;
    s.cfg_val = '0;
    s.typed = 1'b0;
    s.t_feas = 1'b0;
    s.t_best = '0;
    return s;
  endfunction

  function automatic step_t mk_cfg(logic [1:0] idx, int val);
    step_t s;
    s = mk_word(FN_OBJ, 0, 0, 0, 0, 0);
    s.kind = ROW_CFG;
    s.cfg_idx = idx;
    s.cfg_val = 11'(val);
    return s;
  endfunction

  function automatic step_t mk_solve(bit typed, bit f, logic signed [31:0] b);
    step_t s;
    s = mk_word(FN_SOLVE, 0, 0, 0, 0, 0);
    s.typed = typed;
    s.t_feas = f;
    s.t_best = b;
    return s;
  endfunction

  function automatic int rand_coeff();
    if ($urandom_range(0, 3) == 0) return $signed(16'($urandom()));
    return $signed($urandom_range(0, 40)) - 20;
  endfunction

  function automatic int rand_rhs();
    if ($urandom_range(0, 7) == 0) return $signed(24'($urandom()));
    return $signed($urandom_range(0, 80)) - 40;
  endfunction

  task automatic random_problem(ref int sent);
    int nwords;
    int vmax;
    int rmax;
    int fsel;
    step_t s;
    if ($urandom_range(0, 2) != 0) begin
      in_tvalid <= 1'b0;
      drain_and_settle();
      write_reg(CFG_SENSE, 11'($urandom_range(0, 1)));
      if ($urandom_range(0, 14) == 0) begin
        write_reg(CFG_NROWS, $urandom_range(0, 1) ? 11'd1024 : 11'd2047);
        write_reg(CFG_NVARS, 11'($urandom_range(1, 3)));
      end else begin
        write_reg(CFG_NROWS, 11'($urandom_range(0, 4)));
        case ($urandom_range(0, 9))
          0:       write_reg(CFG_NVARS, $urandom_range(0, 1) ? 11'd64 : 11'd127);
          1:       write_reg(CFG_NVARS, 11'd0);
          default: write_reg(CFG_NVARS, 11'($urandom_range(1, 8)));
        endcase
      end
    end else if ($urandom_range(0, 3) == 0) begin
      hold_long = 1;
    end
    vmax = (nvars_r == 0) ? 0 : ((nvars_r > MAX_VARS) ? MAX_VARS - 1 : nvars_r - 1);
    rmax = (nrows_r > 4) ? 3 : int'(nrows_r);
    nwords = (nrows_r > 4) ? $urandom_range(2, 4) : $urandom_range(4, 18);
    for (int k = 0; k < nwords; k++) begin
      fsel = $urandom_range(0, 9);
      if (fsel < 4)
        s = mk_word(FN_OBJ, $urandom_range(0, 1023), $urandom_range(0, vmax),
                    rand_coeff(), $urandom_range(0, 3), rand_rhs());
      else if (fsel < 7)
        s = mk_word(FN_COEF, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                    : $urandom_range(0, rmax), $urandom_range(0, vmax), rand_coeff(),
                    $urandom_range(0, 3), rand_rhs());
      else
        s = mk_word(FN_ROW, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                    : $urandom_range(0, rmax), $urandom_range(0, 63), rand_coeff(),
                    $urandom_range(0, 3), rand_rhs());
      if (nvars_r > 10 && s.func != FN_ROW && $urandom_range(0, 1) == 0)
        s.var_req = 6'($urandom_range(0, 63));
      send_word(s);
      sent++;
    end
    send_word(mk_solve(0, 0, 0));
    sent++;
  endtask

  // result side
  initial begin
    int stall;
    verdict_t want;
    logic signed [31:0] got_best;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 6);
      if (hold_long) begin
        stall = 200_000;
        hold_long = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got_best = out_tdata[32:1];
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: feasible=%0d best=%0d", out_tdata[0], got_best);
      end else begin
        want = pending_q.pop_front();
        solves_seen++;
        if (out_tdata[0] != want.feas || got_best != want.best) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("solve %0d: expected feasible=%0d best=%0d, got feasible=%0d best=%0d",
                     solves_seen, want.feas, want.best, out_tdata[0], got_best);
        end
      end
    end
  end

  initial begin
    int sent;
    cycles = 0;
    mismatches = 0;
    solves_seen = 0;
    hold_long = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FN_OBJ;
    cfg_we = 1'b0;
    cfg_addr = CFG_SENSE;
    cfg_wdata = '0;
    sense_r = 1;
    nvars_r = 1;
    nrows_r = 0;
    clear_problem();

    directed.push_back(mk_solve(1, 1, 0));
    directed.push_back(mk_cfg(CFG_SENSE, 0));
    directed.push_back(mk_cfg(CFG_NROWS, 1));
    directed.push_back(mk_word(FN_ROW, 0, 0, 0, REL_GE, 1));
    directed.push_back(mk_solve(1, 0, SUM_MAX));
    directed.push_back(mk_cfg(CFG_SENSE, 1));
    directed.push_back(mk_word(FN_ROW, 0, 0, 0, REL_GE, 1));
    directed.push_back(mk_solve(1, 0, SUM_MIN));
    directed.push_back(mk_cfg(CFG_NVARS, 127));
    directed.push_back(mk_cfg(CFG_NROWS, 2047));
    directed.push_back(mk_word(FN_OBJ, 0, 0, 32767, 0, 0));
    directed.push_back(mk_word(FN_OBJ, 0, 63, -32768, 0, 0));
    directed.push_back(mk_word(FN_COEF, 1023, 63, -1, 0, 0));
    directed.push_back(mk_word(FN_ROW, 1023, 0, 0, REL_EQ, -1));
    directed.push_back(mk_solve(0, 0, 0));
    directed.push_back(mk_cfg(CFG_NVARS, 3));
    directed.push_back(mk_cfg(CFG_NROWS, 1));
    directed.push_back(mk_word(FN_ROW, 0, 0, 0, 3, 8388607));
    directed.push_back(mk_word(FN_COEF, 0, 1, -32768, 0, 0));
    directed.push_back(mk_word(FN_OBJ, 0, 2, 5, 0, 0));
    directed.push_back(mk_word(FN_ROW, 1, 0, 0, REL_LE, -8388608));
    directed.push_back(mk_solve(0, 0, 0));
    directed.push_back(mk_cfg(CFG_NVARS, 0));
    directed.push_back(mk_word(FN_OBJ, 0, 0, -7, 0, 0));
    directed.push_back(mk_solve(1, 1, 0));
    directed.push_back(mk_cfg(CFG_NROWS, 0));
    directed.push_back(mk_cfg(CFG_NVARS, 4));
    directed.push_back(mk_word(FN_OBJ, 0, 1, 9, 0, 0));
    directed.push_back(mk_word(FN_OBJ, 0, 3, -4, 0, 0));
    directed.push_back(mk_solve(1, 1, 9));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) run_step(directed[i]);

    // hold the receiver while two more solves queue up behind the held result
    hold_long = 1;
    send_word(mk_solve(0, 0, 0));
    send_word(mk_solve(0, 0, 0));

    sent = 0;
    while (sent < 530) random_problem(sent);
    in_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0)
      $display("binary_program_branch_and_bound verification clean");
    else
      $display("binary_program_branch_and_bound verification failed");
    $finish;
  end

endmodule

// File: files.f
rtl/bpbb_pkg.sv
rtl/bpbb_ram.sv
rtl/bpbb_alu.sv
rtl/bpbb_seq.sv
rtl/binary_program_branch_and_bound.sv
sim/tb_top.sv
